// File: rtl/swmm_pkg.sv
package swmm_pkg;

	localparam int RES_W = 32;
	localparam int CFG_W = 7;

	typedef struct packed {
		logic signed [RES_W-1:0] window_min;
		logic signed [RES_W-1:0] window_max;
	} res_t;

	// upd: cells advance; with_x: a sample enters; grow: keep own contents
	typedef struct packed {
		logic upd;
		logic with_x;
		logic grow;
	} cell_ctrl_t;

endpackage

// File: rtl/swmm_if.sv
interface swmm_smp_if #(parameter int W = 32) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface swmm_res_if ();
	logic                               valid;
	logic                               ready;
	logic signed [swmm_pkg::RES_W-1:0] window_min;
	logic signed [swmm_pkg::RES_W-1:0] window_max;

	modport source (output valid, output window_min, output window_max, input ready);
	modport sink (input valid, input window_min, input window_max, output ready);
endinterface

interface swmm_cfg_if ();
	logic                       valid;
	logic                       ready;
	logic [swmm_pkg::CFG_W-1:0] window_size;

	modport source (output valid, output window_size, input ready);
	modport sink (input valid, input window_size, output ready);
endinterface

// File: rtl/swmm_cell.sv
module swmm_cell #(
	parameter int W  = 32,
	parameter int N  = 64,
	parameter int K  = 0,
	parameter int LW = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  swmm_pkg::cell_ctrl_t ctrl,
	input  logic [LW-1:0]        lnew,
	input  logic signed [W-1:0]  x,
	input  logic                 nb_valid,
	input  logic signed [W-1:0]  nb_min,
	input  logic signed [W-1:0]  nb_max,
	output logic                 valid,
	output logic signed [W-1:0]  vmin,
	output logic signed [W-1:0]  vmax,
	output logic                 nxt_valid,
	output logic signed [W-1:0]  nxt_min,
	output logic signed [W-1:0]  nxt_max
);

	localparam logic [LW:0] KV = (LW+1)'(K);
	localparam logic [LW:0] NV = (LW+1)'(N);

	logic                valid_q;
	logic signed [W-1:0] min_q;
	logic signed [W-1:0] max_q;
	logic                active;
	logic                src_v;
	logic signed [W-1:0] src_min;
	logic signed [W-1:0] src_max;

	// cell K covers K + L - N + 1 most recent samples
	assign active  = (KV + {1'b0, lnew}) >= NV;
	assign src_v   = ctrl.grow ? valid_q : nb_valid;
	assign src_min = ctrl.grow ? min_q : nb_min;
	assign src_max = ctrl.grow ? max_q : nb_max;

	always_comb begin
		nxt_valid = active && (ctrl.with_x || src_v);
		nxt_min   = src_min;
		nxt_max   = src_max;
		if (ctrl.with_x) begin
			nxt_min = (!src_v || x < src_min) ? x : src_min;
			nxt_max = (!src_v || x > src_max) ? x : src_max;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.upd) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.upd) begin
			min_q <= nxt_min;
			max_q <= nxt_max;
		end
	end

	assign valid = valid_q;
	assign vmin  = min_q;
	assign vmax  = max_q;

endmodule

// File: rtl/swmm_obuf.sv
module swmm_obuf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  swmm_pkg::res_t      din,
	swmm_res_if.source          res,
	output logic                full
);

	swmm_pkg::res_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;
	logic           pop;

	assign pop            = res.valid && res.ready;
	assign res.valid      = cnt_q != 2'd0;
	assign res.window_min = ent_q[rp_q].window_min;
	assign res.window_max = ent_q[rp_q].window_max;
	assign full           = cnt_q == 2'd2;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef SYNTH
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("obuf count out of range");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("obuf push while full");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.window_min)
		&& $stable(res.window_max)) else $error("result word changed while waiting");
`endif

endmodule

// File: rtl/sliding_window_min_max.sv
// channel   | modport | word
// samples   | sink    | sample (SAMPLE_WIDTH, signed)
// results   | source  | window_min, window_max (32, signed)
// cfg       | sink    | window_size (7, unsigned), always ready
//
// One sample per cycle, when samples.ready is high, through a row of
// WINDOW_MAX min/max cells; each result word goes into the result buffer.
// After window_size is lowered, a waiting sample is held while the surplus
// entries are dropped (at most WINDOW_MAX - 1 entries).
// Reset clears cell valid flags, counters and the two-word result buffer.
// samples.ready also drops while that buffer holds two words.
module sliding_window_min_max #(
	parameter int WINDOW_MAX   = 64,
	parameter int SAMPLE_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	swmm_smp_if.sink   samples,
	swmm_res_if.source results,
	swmm_cfg_if.sink   cfg
);

	localparam int N  = WINDOW_MAX;
	localparam int W  = SAMPLE_WIDTH;
	localparam int LW = $clog2(N + 1);
	localparam int CW = (LW > swmm_pkg::CFG_W) ? LW : swmm_pkg::CFG_W;
	localparam logic [CW-1:0] NC = CW'(N);
	localparam logic [LW-1:0] NL = LW'(N);

	logic [swmm_pkg::CFG_W-1:0] win_raw_q;
	logic [CW-1:0]              raw_w;
	logic [CW-1:0]              win_c;
	logic [LW-1:0]              win;
	logic [LW-1:0]              l_q;
	logic [LW-1:0]              lnew;
	logic [LW-1:0]              cnt_q;
	logic [LW-1:0]              cnt_n;
	logic                       filled_q;
	logic                       filled_n;
	logic                       need_drop;
	logic                       acc;
	logic                       full;
	logic                       push;
	swmm_pkg::cell_ctrl_t       ctrl;
	swmm_pkg::res_t             din;
	logic signed [W-1:0]        x;

	logic                cv   [N];
	logic signed [W-1:0] cmin [N];
	logic signed [W-1:0] cmax [N];
	logic                last_v;
	logic signed [W-1:0] last_min;
	logic signed [W-1:0] last_max;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_raw_q <= swmm_pkg::CFG_W'(1);
		end else if (cfg.valid && cfg.ready) begin
			win_raw_q <= cfg.window_size;
		end
	end

	assign raw_w = CW'(win_raw_q);
	assign win_c = (raw_w == '0) ? CW'(1) : ((raw_w > NC) ? NC : raw_w);
	assign win   = LW'(win_c);

	assign x             = samples.sample;
	assign need_drop     = l_q > win;
	assign samples.ready = !need_drop && !full;
	assign acc           = samples.valid && samples.ready;

	// a lowered window takes effect only once the next sample is waiting
	always_comb begin
		ctrl.upd    = acc || (need_drop && samples.valid);
		ctrl.with_x = acc;
		ctrl.grow   = acc && (l_q < win);
		if (acc) begin
			lnew = ctrl.grow ? l_q + LW'(1) : l_q;
		end else begin
			lnew = l_q - LW'(1);
		end
	end

	assign cnt_n    = (cnt_q == NL) ? cnt_q : cnt_q + LW'(1);
	assign filled_n = filled_q || (cnt_n >= win);
	assign push     = acc && filled_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q      <= '0;
			cnt_q    <= '0;
			filled_q <= 1'b0;
		end else begin
			if (ctrl.upd) begin
				l_q <= lnew;
			end
			if (acc) begin
				cnt_q    <= cnt_n;
				filled_q <= filled_n;
			end
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_cell
		if (k == 0 && N == 1) begin : g_only
			swmm_cell #(.W(W), .N(N), .K(k), .LW(LW)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .lnew(lnew), .x(x),
				.nb_valid(1'b0), .nb_min('0), .nb_max('0),
				.valid(cv[k]), .vmin(cmin[k]), .vmax(cmax[k]),
				.nxt_valid(last_v), .nxt_min(last_min), .nxt_max(last_max)
			);
		end else if (k == 0) begin : g_first
			swmm_cell #(.W(W), .N(N), .K(k), .LW(LW)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .lnew(lnew), .x(x),
				.nb_valid(1'b0), .nb_min('0), .nb_max('0),
				.valid(cv[k]), .vmin(cmin[k]), .vmax(cmax[k]),
				.nxt_valid(), .nxt_min(), .nxt_max()
			);
		end else if (k == N - 1) begin : g_last
			swmm_cell #(.W(W), .N(N), .K(k), .LW(LW)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .lnew(lnew), .x(x),
				.nb_valid(cv[k-1]), .nb_min(cmin[k-1]), .nb_max(cmax[k-1]),
				.valid(cv[k]), .vmin(cmin[k]), .vmax(cmax[k]),
				.nxt_valid(last_v), .nxt_min(last_min), .nxt_max(last_max)
			);
		end else begin : g_mid
			swmm_cell #(.W(W), .N(N), .K(k), .LW(LW)) u_cell (
				.clk(clk), .arst_n(arst_n), .ctrl(ctrl), .lnew(lnew), .x(x),
				.nb_valid(cv[k-1]), .nb_min(cmin[k-1]), .nb_max(cmax[k-1]),
				.valid(cv[k]), .vmin(cmin[k]), .vmax(cmax[k]),
				.nxt_valid(), .nxt_min(), .nxt_max()
			);
		end
	end

	if (W >= swmm_pkg::RES_W) begin : g_trunc
		assign din.window_min = last_min[swmm_pkg::RES_W-1:0];
		assign din.window_max = last_max[swmm_pkg::RES_W-1:0];
	end else begin : g_sext
		assign din.window_min = {{(swmm_pkg::RES_W-W){last_min[W-1]}}, last_min};
		assign din.window_max = {{(swmm_pkg::RES_W-W){last_max[W-1]}}, last_max};
	end

	swmm_obuf u_obuf (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.din(din),
		.res(results),
		.full(full)
	);

`ifndef SYNTH
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		l_q <= NL) else $error("window length above maximum");
	a_acc_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> l_q <= win) else $error("sample taken while dropping entries");
	a_acc_len: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> l_q != '0) else $error("empty window after a sample");
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> last_v) else $error("result from an empty last cell");
`endif

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int WIN_CAP   = 64;
	localparam int QUIET_CYC = 16;
	localparam int LIMIT     = 1000000;
	localparam int SIDE_MIN  = 0;
	localparam int SIDE_MAX  = 1;

	localparam logic signed [31:0] S_LO = 32'sh8000_0000;
	localparam logic signed [31:0] S_HI = 32'sh7fff_ffff;

	typedef enum int {SH_NOISE, SH_TIES, SH_RISE, SH_FALL, SH_EDGE} shape_t;
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_t;

	logic clk;
	logic arst_n;

	swmm_smp_if #(.W(32)) smp_ch ();
	swmm_res_if           res_ch ();
	swmm_cfg_if           cfg_ch ();

	sliding_window_min_max #(
		.WINDOW_MAX(WIN_CAP),
		.SAMPLE_WIDTH(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.samples(smp_ch),
		.results(res_ch),
		.cfg(cfg_ch)
	);

	logic signed [31:0] smp_backlog[$];
	swmm_pkg::res_t     extremes_q[$];

	logic signed [31:0] q_val [2][WIN_CAP];
	logic [15:0]        q_pos [2][WIN_CAP];
	int                 q_cnt [2];
	logic [15:0]        pos_cnt;
	bit                 filled;
	logic [6:0]         win_reg;

	int send_idle;
	int recv_stall;
	int mismatches;
	int cycle_cnt;
	bit smp_took;
	bit cfg_took;

	bit             nxt_got;
	swmm_pkg::res_t nxt_res;
	swmm_pkg::res_t exp_res;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic slide_window(input logic signed [31:0] x, output bit got,
		output swmm_pkg::res_t r);
		int w;
		int sd;
		int drop;
		int i;
		logic [15:0] age;
		w = (win_reg == 0) ? 1 : ((win_reg > WIN_CAP) ? WIN_CAP : int'(win_reg));
		pos_cnt = pos_cnt + 16'd1;
		for (sd = 0; sd < 2; sd++) begin
			drop = 0;
			while (drop < q_cnt[sd]) begin
				age = pos_cnt - q_pos[sd][drop];
				if (age < w)
					break;
				drop++;
			end
			for (i = 0; i + drop < q_cnt[sd]; i++) begin
				q_val[sd][i] = q_val[sd][i + drop];
				q_pos[sd][i] = q_pos[sd][i + drop];
			end
			q_cnt[sd] -= drop;
		end
		for (sd = 0; sd < 2; sd++) begin
			while (q_cnt[sd] > 0 && ((sd == SIDE_MAX) ? (q_val[sd][q_cnt[sd] - 1] <= x)
					: (q_val[sd][q_cnt[sd] - 1] >= x)))
				q_cnt[sd]--;
			if (q_cnt[sd] < WIN_CAP) begin
				q_val[sd][q_cnt[sd]] = x;
				q_pos[sd][q_cnt[sd]] = pos_cnt;
				q_cnt[sd]++;
			end
		end
		if (int'(pos_cnt) >= w)
			filled = 1'b1;
		got = filled;
		r.window_min = q_val[SIDE_MIN][0];
		r.window_max = q_val[SIDE_MAX][0];
	endtask

	// driver: sample valid/data and result ready change on the falling edge
	always @(negedge clk) begin
		if (!arst_n) begin
			smp_ch.valid <= 1'b0;
			res_ch.ready <= 1'b0;
		end else begin
			if (!smp_ch.valid || smp_took) begin
				if (smp_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
					smp_ch.valid  <= 1'b1;
					smp_ch.sample <= smp_backlog[0];
					smp_backlog.delete(0);
				end else begin
					smp_ch.valid <= 1'b0;
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			smp_took <= smp_ch.valid && smp_ch.ready;
			cfg_took <= cfg_ch.valid && cfg_ch.ready;
			if (cfg_ch.valid && cfg_ch.ready)
				win_reg = cfg_ch.window_size;
			if (smp_ch.valid && smp_ch.ready) begin
				slide_window(smp_ch.sample, nxt_got, nxt_res);
				if (nxt_got)
					extremes_q.insert(extremes_q.size(), nxt_res);
			end
			if (res_ch.valid && res_ch.ready) begin
				if (extremes_q.size() == 0) begin
					$error("unexpected word: window_min %0d window_max %0d",
						res_ch.window_min, res_ch.window_max);
					mismatches++;
				end else begin
					exp_res = extremes_q[0];
					extremes_q.delete(0);
					if (res_ch.window_min !== exp_res.window_min) begin
						$error("window_min: expected %0d, got %0d",
							exp_res.window_min, res_ch.window_min);
						mismatches++;
					end
					if (res_ch.window_max !== exp_res.window_max) begin
						$error("window_max: expected %0d, got %0d",
							exp_res.window_max, res_ch.window_max);
						mismatches++;
					end
				end
			end
		end
	end

	task automatic wait_quiet();
		do
			@(posedge clk);
		while (smp_backlog.size() != 0 || smp_ch.valid || extremes_q.size() != 0);
		repeat (QUIET_CYC) @(negedge clk);
	endtask

	task automatic write_window(input logic [6:0] w);
		wait_quiet();
		cfg_ch.window_size <= w;
		cfg_ch.valid       <= 1'b1;
		do
			@(negedge clk);
		while (!cfg_took);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_idle(input idle_t m);
		send_idle  = (m == IDLE_SEND) ? 65 : ((m == IDLE_BOTH) ? 13 : 0);
		recv_stall = (m == IDLE_RECV) ? 65 : ((m == IDLE_BOTH) ? 13 : 0);
	endtask

	// runs of ramps and near-equal values build deep queues; noise and extremes break them
	task automatic queue_samples(input int n);
		int k;
		int run;
		int pick;
		shape_t sh;
		logic signed [31:0] v;
		logic signed [31:0] step;
		k = 0;
		while (k < n) begin
			pick = $urandom_range(99);
			sh = (pick < 25) ? SH_TIES : (pick < 50) ? SH_RISE : (pick < 75) ? SH_FALL
				: (pick < 90) ? SH_NOISE : SH_EDGE;
			run  = $urandom_range(1, 24);
			v    = $urandom;
			step = $urandom_range(1, 1 << $urandom_range(0, 20));
			for (int j = 0; j < run && k < n; j++) begin
				case (sh)
					SH_NOISE: v = $urandom;
					SH_TIES: v = $signed(32'($urandom_range(8))) - 32'sd4;
					SH_RISE: v = v + step;
					SH_FALL: v = v - step;
					default: begin
						case ($urandom_range(4))
							0: v = S_LO;
							1: v = S_HI;
							2: v = 32'sd0;
							3: v = -32'sd1;
							default: v = 32'sd1;
						endcase
					end
				endcase
				smp_backlog.insert(smp_backlog.size(), v);
				k++;
			end
		end
	endtask

	initial begin
		logic [6:0] w;
		smp_ch.valid       = 1'b0;
		smp_ch.sample      = '0;
		res_ch.ready       = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.window_size = '0;
		q_cnt[SIDE_MIN]    = 0;
		q_cnt[SIDE_MAX]    = 0;
		pos_cnt            = '0;
		filled             = 1'b0;
		win_reg            = 7'd1;
		mismatches         = 0;
		cycle_cnt          = 0;
		smp_took           = 1'b0;
		cfg_took           = 1'b0;
		set_idle(IDLE_NONE);
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset window of one
		smp_backlog = '{S_LO, S_HI, 32'sd0, -32'sd1, 32'sd1};
		wait_quiet();

		write_window(7'd4);
		smp_backlog = '{32'sd5, 32'sd5, 32'sd3, 32'sd3, 32'sd7, 32'sd7, -32'sd2, -32'sd2,
			32'sd9, 32'sd1};

		write_window(7'd0);
		smp_backlog = '{S_HI, S_LO};

		// saturates, then shrink with old entries expiring at once
		write_window(7'd127);
		smp_backlog = '{32'sd1, 32'sd2, 32'sd3};
		write_window(7'd2);
		smp_backlog = '{32'sd4, -32'sd5, 32'sd6};

		for (int p = 0; p < 21; p++) begin
			case (p)
				0: w = 7'd1;
				1: w = 7'd64;
				2: w = 7'd0;
				3: w = 7'd127;
				4: w = 7'd65;
				5: w = 7'd63;
				6: w = 7'd2;
				7: w = 7'd33;
				default: w = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
					: 7'($urandom_range(1, 20));
			endcase
			write_window(w);
			set_idle(idle_t'(p % 4));
			queue_samples(92);
		end

		wait_quiet();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
rtl/swmm_pkg.sv
rtl/swmm_if.sv
rtl/swmm_cell.sv
rtl/swmm_obuf.sv
rtl/sliding_window_min_max.sv
tb/sv/tb_top.sv
